>>> design/bclu_pkg.sv
// ----------------------------------------------------------------------------
// bclu_pkg: shared types and constants of the 12-hour clock display updater
// Digit limits, reset time, display addresses, frame lead and segment table.
// ----------------------------------------------------------------------------
package bclu_pkg;

  localparam int DIGIT_W = 4;
  localparam int COUNT_W = 8;
  localparam int ADDR_W  = 6;
  localparam int SEG_W   = 8;
  localparam int FRAME_W = 18;

  typedef logic [DIGIT_W-1:0] digit_t;

  localparam logic [COUNT_W-1:0] MAX_ELAPSED = 8'd255;

  localparam digit_t ONES_LAST = 4'd9;
  localparam digit_t TENS_LAST = 4'd5;

  localparam digit_t RST_SEC_ONES = 4'd0;
  localparam digit_t RST_SEC_TENS = 4'd0;
  localparam digit_t RST_MIN_ONES = 4'd7;
  localparam digit_t RST_MIN_TENS = 4'd0;
  localparam logic   RST_HOUR_TENS = 1'b1;
  localparam digit_t RST_HOUR_ONES = 4'd1;

  localparam logic [2:0] FRAME_LEAD = 3'b101;

  localparam logic [ADDR_W-1:0] ADDR_MIN_ONES  = 6'd0;
  localparam logic [ADDR_W-1:0] ADDR_MIN_TENS  = 6'd2;
  localparam logic [ADDR_W-1:0] ADDR_HOUR_ONES = 6'd4;
  localparam logic [ADDR_W-1:0] ADDR_HOUR_TENS = 6'd6;

  localparam logic [1:0] WR_MIN_ONES  = 2'd0;
  localparam logic [1:0] WR_MIN_TENS  = 2'd1;
  localparam logic [1:0] WR_HOUR_ONES = 2'd2;
  localparam logic [1:0] WR_HOUR_TENS = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_CHECK,
    ST_WRITE
  } upd_state_t;

  function automatic logic [SEG_W-1:0] seg_lut(input digit_t d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 8'hEB;
      4'd1:    s = 8'h60;
      4'd2:    s = 8'hC7;
      4'd3:    s = 8'hE5;
      4'd4:    s = 8'h6C;
      4'd5:    s = 8'hAD;
      4'd6:    s = 8'hAF;
      4'd7:    s = 8'hE0;
      4'd8:    s = 8'hEF;
      4'd9:    s = 8'hED;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

>>> design/bclu_in_if.sv
// ----------------------------------------------------------------------------
// bclu_in_if: request channel carrying elapsed second counts
// Valid/ready handshake with the elapsed count as payload.
// ----------------------------------------------------------------------------
interface bclu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] elapsed_seconds;

  modport source (output valid, output elapsed_seconds, input ready);
  modport sink   (input valid, input elapsed_seconds, output ready);
endinterface

>>> design/bclu_out_if.sv
// ----------------------------------------------------------------------------
// bclu_out_if: request channel carrying display controller writes
// Valid/ready handshake with address, segment byte, frame and last flag.
// ----------------------------------------------------------------------------
interface bclu_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  lcd_address;
  logic [7:0]  segment_data;
  logic [17:0] frame;
  logic        last_write;

  modport source (output valid, output lcd_address, output segment_data,
                  output frame, output last_write, input ready);
  modport sink   (input valid, input lcd_address, input segment_data,
                  input frame, input last_write, output ready);
endinterface

>>> design/bclu_digit_cell.sv
// ----------------------------------------------------------------------------
// bclu_digit_cell: one BCD digit of the clock chain
// Counts up on carry in, wraps to zero after its last value and passes the
// carry on to the next cell.
// ----------------------------------------------------------------------------
module bclu_digit_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  bclu_pkg::digit_t init_val,
  input  bclu_pkg::digit_t last_val,
  input  logic            carry_in,
  output bclu_pkg::digit_t digit_o,
  output logic            carry_out
);
  import bclu_pkg::*;

  digit_t digit_r;
  digit_t digit_nxt;
  logic   wrap;

  assign wrap      = (digit_r == last_val);
  assign carry_out = carry_in && wrap;
  assign digit_o   = digit_r;

  always_comb begin
    digit_nxt = digit_r;
    if (carry_in) begin
      digit_nxt = wrap ? '0 : digit_r + digit_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r <= init_val;
    end else begin
      digit_r <= digit_nxt;
    end
  end

endmodule

>>> design/bclu_hour_cell.sv
// ----------------------------------------------------------------------------
// bclu_hour_cell: hour end of the clock chain
// Counts hours 1 to 12, where 12 is followed by 1.
// ----------------------------------------------------------------------------
module bclu_hour_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             carry_in,
  output logic             hour_tens_o,
  output bclu_pkg::digit_t hour_ones_o
);
  import bclu_pkg::*;

  logic   tens_r;
  logic   tens_nxt;
  digit_t ones_r;
  digit_t ones_nxt;

  assign hour_tens_o = tens_r;
  assign hour_ones_o = ones_r;

  always_comb begin
    tens_nxt = tens_r;
    ones_nxt = ones_r;
    if (carry_in) begin
      if (tens_r && ones_r == 4'd2) begin
        tens_nxt = 1'b0;
        ones_nxt = 4'd1;
      end else if (!tens_r && ones_r == ONES_LAST) begin
        tens_nxt = 1'b1;
        ones_nxt = '0;
      end else begin
        ones_nxt = ones_r + digit_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tens_r <= RST_HOUR_TENS;
      ones_r <= RST_HOUR_ONES;
    end else begin
      tens_r <= tens_nxt;
      ones_r <= ones_nxt;
    end
  end

endmodule

>>> design/bcd_12h_clock_lcd_updater_core.sv
// ----------------------------------------------------------------------------
// bcd_12h_clock_lcd_updater_core: 12-hour BCD clock with display refresh
// Usage:
// Each input request carries the number of seconds elapsed since the last
// one. The block steps a chain of digit cells (seconds ones and tens,
// minutes ones and tens, then the hour cell) one second per cycle, then
// compares the hour and minute digits with those last sent to the display.
// If they differ, four output requests follow, one per cycle while the
// receiver is ready: minute ones, minute tens, hour ones, hour tens, the
// last one flagged by last_write. A zero count is taken and dropped.
// The input is ready only while the block is idle, so a new item is not
// taken before the last one is stepped, checked and written out. A stalled
// receiver holds the current write and the block.
// Reset sets the clock to 11:07:00 and the shown digits to zeros, so the
// first nonzero item always refreshes the display.
// ----------------------------------------------------------------------------
module bcd_12h_clock_lcd_updater_core (
  input  logic        clk,
  input  logic        rst_n,
  bclu_in_if.sink     in_ch,
  bclu_out_if.source  out_ch
);
  import bclu_pkg::*;

  upd_state_t         state_r;
  upd_state_t         state_nxt;
  logic [COUNT_W-1:0] cnt_r;
  logic [COUNT_W-1:0] cnt_nxt;
  logic [1:0]         wr_idx_r;
  logic [1:0]         wr_idx_nxt;

  logic   shown_ht_r;
  logic   shown_ht_nxt;
  digit_t shown_ho_r;
  digit_t shown_ho_nxt;
  digit_t shown_mt_r;
  digit_t shown_mt_nxt;
  digit_t shown_mo_r;
  digit_t shown_mo_nxt;

  logic   tick;
  logic   c_s1;
  logic   c_s10;
  logic   c_m1;
  logic   c_m10;
  digit_t sec_ones;
  digit_t sec_tens;
  digit_t min_ones;
  digit_t min_tens;
  logic   hour_tens;
  digit_t hour_ones;
  logic   differs;

  logic [ADDR_W-1:0] wr_addr;
  logic [SEG_W-1:0]  wr_data;

  bclu_digit_cell u_sec_ones (
    .clk(clk), .rst_n(rst_n), .init_val(RST_SEC_ONES), .last_val(ONES_LAST),
    .carry_in(tick), .digit_o(sec_ones), .carry_out(c_s1)
  );

  bclu_digit_cell u_sec_tens (
    .clk(clk), .rst_n(rst_n), .init_val(RST_SEC_TENS), .last_val(TENS_LAST),
    .carry_in(c_s1), .digit_o(sec_tens), .carry_out(c_s10)
  );

  bclu_digit_cell u_min_ones (
    .clk(clk), .rst_n(rst_n), .init_val(RST_MIN_ONES), .last_val(ONES_LAST),
    .carry_in(c_s10), .digit_o(min_ones), .carry_out(c_m1)
  );

  bclu_digit_cell u_min_tens (
    .clk(clk), .rst_n(rst_n), .init_val(RST_MIN_TENS), .last_val(TENS_LAST),
    .carry_in(c_m1), .digit_o(min_tens), .carry_out(c_m10)
  );

  bclu_hour_cell u_hour (
    .clk(clk), .rst_n(rst_n), .carry_in(c_m10),
    .hour_tens_o(hour_tens), .hour_ones_o(hour_ones)
  );

  assign differs = (shown_ht_r != hour_tens) || (shown_ho_r != hour_ones) ||
                   (shown_mt_r != min_tens) || (shown_mo_r != min_ones);

  always_comb begin
    case (wr_idx_r)
      WR_MIN_ONES: begin
        wr_addr = ADDR_MIN_ONES;
        wr_data = seg_lut(shown_mo_r);
      end
      WR_MIN_TENS: begin
        wr_addr = ADDR_MIN_TENS;
        wr_data = seg_lut(shown_mt_r);
      end
      WR_HOUR_ONES: begin
        wr_addr = ADDR_HOUR_ONES;
        wr_data = seg_lut(shown_ho_r);
      end
      default: begin
        wr_addr = ADDR_HOUR_TENS;
        wr_data = shown_ht_r ? seg_lut(digit_t'(1)) : '0;
      end
    endcase
  end

  assign out_ch.lcd_address  = wr_addr;
  assign out_ch.segment_data = wr_data;
  assign out_ch.frame        = {FRAME_LEAD, wr_addr, wr_data, 1'b0};
  assign out_ch.last_write   = (wr_idx_r == WR_HOUR_TENS);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    wr_idx_nxt   = wr_idx_r;
    shown_ht_nxt = shown_ht_r;
    shown_ho_nxt = shown_ho_r;
    shown_mt_nxt = shown_mt_r;
    shown_mo_nxt = shown_mo_r;
    tick         = 1'b0;
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid && in_ch.elapsed_seconds != '0) begin
          cnt_nxt   = (in_ch.elapsed_seconds > MAX_ELAPSED) ? MAX_ELAPSED
                                                            : in_ch.elapsed_seconds;
          state_nxt = ST_TICK;
        end
      end
      ST_TICK: begin
        tick    = 1'b1;
        cnt_nxt = cnt_r - COUNT_W'(1);
        if (cnt_r == COUNT_W'(1)) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (differs) begin
          shown_ht_nxt = hour_tens;
          shown_ho_nxt = hour_ones;
          shown_mt_nxt = min_tens;
          shown_mo_nxt = min_ones;
          wr_idx_nxt   = WR_MIN_ONES;
          state_nxt    = ST_WRITE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WRITE: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready) begin
          if (wr_idx_r == WR_HOUR_TENS) begin
            state_nxt = ST_IDLE;
          end else begin
            wr_idx_nxt = wr_idx_r + 2'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      wr_idx_r   <= WR_MIN_ONES;
      shown_ht_r <= 1'b0;
      shown_ho_r <= '0;
      shown_mt_r <= '0;
      shown_mo_r <= '0;
    end else begin
      state_r    <= state_nxt;
      wr_idx_r   <= wr_idx_nxt;
      shown_ht_r <= shown_ht_nxt;
      shown_ho_r <= shown_ho_nxt;
      shown_mt_r <= shown_mt_nxt;
      shown_mo_r <= shown_mo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
  end

endmodule

>>> sim/bclu_write_checker.sv
// ----------------------------------------------------------------------------
// bclu_write_checker: display write predictor and scoreboard
// Follows every accepted elapsed-seconds request with its own copy of the
// BCD 12-hour clock and the digits last shown. It queues the four display
// writes that a change of the shown digits causes and compares every
// accepted write with the oldest one queued, field by field.
// ----------------------------------------------------------------------------
module bclu_write_checker (
  input  logic  clk,
  input  logic  rst_n,
  bclu_in_if    in_mon,
  bclu_out_if   out_mon,
  output int    fail_count,
  output int    writes_pending
);
  import bclu_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [SEG_W-1:0]   seg;
    logic [FRAME_W-1:0] frame;
    logic               last;
  } lcd_write_t;

  localparam logic [SEG_W-1:0] DIGIT_SEGMENTS [10] = '{
    8'hEB, 8'h60, 8'hC7, 8'hE5, 8'h6C, 8'hAD, 8'hAF, 8'hE0, 8'hEF, 8'hED
  };

  logic       hr_tens;
  digit_t     hr_ones;
  logic [2:0] mn_tens;
  digit_t     mn_ones;
  logic [2:0] sc_tens;
  digit_t     sc_ones;
  digit_t     shown [4];

  lcd_write_t expected_writes [$];
  int         write_idx;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at write %0d: %s", write_idx, what);
    fail_count++;
  endtask

  function automatic logic [SEG_W-1:0] segments_of(input digit_t d);
    return (d <= ONES_LAST) ? DIGIT_SEGMENTS[d] : '0;
  endfunction

  function void advance_clock_second();
    sc_ones = sc_ones + 1'b1;
    if (sc_ones > ONES_LAST) begin
      sc_ones = '0;
      sc_tens = sc_tens + 1'b1;
      if (sc_tens > TENS_LAST) begin
        sc_tens = '0;
        mn_ones = mn_ones + 1'b1;
      end
    end
    if (mn_ones > ONES_LAST) begin
      mn_ones = '0;
      mn_tens = mn_tens + 1'b1;
      if (mn_tens > TENS_LAST) begin
        mn_tens = '0;
        hr_ones = hr_ones + 1'b1;
      end
    end
    if (hr_tens) begin
      if (hr_ones > 4'd2) begin
        hr_tens = 1'b0;
        hr_ones = 4'd1;
      end
    end else if (hr_ones > ONES_LAST) begin
      hr_ones = '0;
      hr_tens = 1'b1;
    end
  endfunction

  function void queue_write(input logic [ADDR_W-1:0] addr, input logic [SEG_W-1:0] seg,
                            input logic last);
    lcd_write_t w;
    w.addr  = addr;
    w.seg   = seg;
    w.frame = {FRAME_LEAD, addr, seg, 1'b0};
    w.last  = last;
    expected_writes.push_back(w);
  endfunction

  function void predict_display_refresh(input logic [COUNT_W-1:0] elapsed);
    int steps;
    steps = (elapsed > MAX_ELAPSED) ? int'(MAX_ELAPSED) : int'(elapsed);
    if (steps == 0) return;
    for (int i = 0; i < steps; i++) advance_clock_second();
    if (shown[0] == digit_t'(hr_tens) && shown[1] == hr_ones &&
        shown[2] == digit_t'(mn_tens) && shown[3] == mn_ones) return;
    shown[0] = digit_t'(hr_tens);
    shown[1] = hr_ones;
    shown[2] = digit_t'(mn_tens);
    shown[3] = mn_ones;
    queue_write(ADDR_MIN_ONES, segments_of(shown[3]), 1'b0);
    queue_write(ADDR_MIN_TENS, segments_of(shown[2]), 1'b0);
    queue_write(ADDR_HOUR_ONES, segments_of(shown[1]), 1'b0);
    queue_write(ADDR_HOUR_TENS, (shown[0] == '0) ? '0 : segments_of(shown[0]), 1'b1);
  endfunction

  always @(posedge clk) begin
    lcd_write_t want;
    if (!rst_n) begin
      hr_tens = RST_HOUR_TENS;
      hr_ones = RST_HOUR_ONES;
      mn_tens = RST_MIN_TENS[2:0];
      mn_ones = RST_MIN_ONES;
      sc_tens = RST_SEC_TENS[2:0];
      sc_ones = RST_SEC_ONES;
      for (int i = 0; i < 4; i++) shown[i] = '0;
      expected_writes.delete();
      write_idx = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_writes.size() == 0) begin
          report_mismatch("write arrived with none expected");
        end else begin
          want = expected_writes.pop_front();
          if (out_mon.lcd_address !== want.addr)
            report_mismatch($sformatf("lcd_address %0d, expected %0d",
                                      out_mon.lcd_address, want.addr));
          if (out_mon.segment_data !== want.seg)
            report_mismatch($sformatf("segment_data %02h, expected %02h",
                                      out_mon.segment_data, want.seg));
          if (out_mon.frame !== want.frame)
            report_mismatch($sformatf("frame %05h, expected %05h",
                                      out_mon.frame, want.frame));
          if (out_mon.last_write !== want.last)
            report_mismatch($sformatf("last_write %0b, expected %0b",
                                      out_mon.last_write, want.last));
        end
        write_idx++;
      end
      if (in_mon.valid && in_mon.ready) predict_display_refresh(in_mon.elapsed_seconds);
    end
    writes_pending <= expected_writes.size();
  end

endmodule

>>> sim/tb_bcd_12h_clock_lcd_updater_core.sv
// ----------------------------------------------------------------------------
// tb_bcd_12h_clock_lcd_updater_core: testbench of the clock display updater
// Sends directed and then random elapsed-second counts, walking the clock
// across minute, hour, twelve-to-one and nine-to-ten rollovers. The sender
// and the display write receiver both stall at random. A separate checker
// predicts and compares the display writes; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_bcd_12h_clock_lcd_updater_core;
  import bclu_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 137;
  localparam int DRAIN_CYCLES = 300;

  logic clk;
  logic rst_n;
  int   cycle_cnt = 0;
  int   fail_count;
  int   writes_pending;

  bclu_in_if  in_ch ();
  bclu_out_if out_ch ();

  bcd_12h_clock_lcd_updater_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bclu_write_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .fail_count     (fail_count),
    .writes_pending (writes_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  function automatic bit in_quiet_window();
    return cycle_cnt >= 12000 && cycle_cnt < 22000;
  endfunction

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= in_quiet_window() || ($urandom_range(99) >= 7);
    end
  end

  task automatic send_seconds(input logic [7:0] secs);
    if (!in_quiet_window() && $urandom_range(99) < 7) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.elapsed_seconds <= secs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic wait_for_display_writes();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (writes_pending != 0) @(posedge clk);
  endtask

  initial begin
    wait (cycle_cnt == CYCLE_LIMIT);
    $display("tb_bcd_12h_clock_lcd_updater_core NOT OK");
    $finish;
  end

  initial begin
    logic [7:0] secs;
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.elapsed_seconds <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A zero count right after reset must not refresh; the first nonzero one must.
    send_seconds(8'd0);
    send_seconds(8'd1);
    send_seconds(8'd0);
    send_seconds(8'd1);
    send_seconds(8'd58);
    send_seconds(8'd1);
    send_seconds(8'd255);
    send_seconds(8'd128);
    send_seconds(8'h55);
    send_seconds(8'hAA);
    for (int i = 0; i < 13; i++) send_seconds(8'd255);
    wait_for_display_writes();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(99) < 85) secs = 8'($urandom_range(255, 180));
      else                         secs = 8'($urandom_range(40, 0));
      send_seconds(secs);
      if (i % 50 == 49) wait_for_display_writes();
    end

    wait_for_display_writes();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && writes_pending == 0) begin
      $display("tb_bcd_12h_clock_lcd_updater_core OK");
    end else begin
      $display("tb_bcd_12h_clock_lcd_updater_core NOT OK");
    end
    $finish;
  end

endmodule
